@@ design/dchc_pkg.sv @@
// Shared types and constants of the drift chamber hit calibrator.
package dchc_pkg;

	localparam int SEC_N = 4;
	localparam int CAL_N = 6;
	localparam int PAIR_N = 2;
	localparam int TIME_W = 16;
	localparam int CTL_W = 18;
	localparam int POS_W = 48;
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic [1:0] CMD_HIT = 2'd0;
	localparam logic [1:0] CMD_WIN_WR = 2'd1;
	localparam logic [1:0] CMD_CAL_WR = 2'd2;

	localparam logic signed [POS_W-1:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
	localparam logic signed [POS_W-1:0] POS_MIN = 48'sh8000_0000_0000;

	typedef struct packed {
		logic [2:0]        pad;
		logic [63:0]       table_word;
		logic [TIME_W-1:0] right_1;
		logic [TIME_W-1:0] right_0;
		logic [TIME_W-1:0] left_1;
		logic [TIME_W-1:0] left_0;
		logic [TIME_W-1:0] drift_3;
		logic [TIME_W-1:0] drift_2;
		logic [TIME_W-1:0] drift_1;
		logic [TIME_W-1:0] drift_0;
		logic [2:0]        entry_index;
		logic [1:0]        detector;
	} in_item_t;

	typedef struct packed {
		logic [1:0]              pad;
		logic signed [CTL_W-1:0] control_value;
		logic signed [POS_W-1:0] position;
		logic [1:0]              section;
		logic [1:0]              det_number;
	} res_t;

	typedef struct packed {
		logic                               is_cal;
		logic [1:0]                         det;
		logic [2:0]                         idx;
		logic [63:0]                        word;
		logic [SEC_N-1:0]                   sec_ok;
		logic [SEC_N-1:0][TIME_W-1:0]       drift;
		logic [SEC_N-1:0][CTL_W-1:0]        csum;
		logic [PAIR_N-1:0][CTL_W-1:0]       diff;
	} q_entry_t;

endpackage

@@ design/dchc_front.sv @@
// Front part: accepts items, holds the window table and classifies the sections of a hit.
module dchc_front #(
	parameter int NUM_DETS = 4,
	parameter int TIME_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [199:0]        s_tdata,
	input  logic [1:0]          s_tuser,
	input  logic                q_full,
	output logic                q_push,
	output dchc_pkg::q_entry_t  q_entry
);

	localparam int DET_W = (NUM_DETS > 1) ? $clog2(NUM_DETS) : 1;
	localparam logic [dchc_pkg::TIME_W-1:0] TMASK = (TIME_BITS >= dchc_pkg::TIME_W) ?
		{dchc_pkg::TIME_W{1'b1}} : dchc_pkg::TIME_W'((32'd1 << TIME_BITS) - 32'd1);

	dchc_pkg::in_item_t in_item;
	logic               accept;
	logic [DET_W-1:0]   det_a;
	logic               in_det_ok;
	logic               win_we;

	logic [63:0]                       win_mem_q [dchc_pkg::SEC_N][NUM_DETS];
	logic [NUM_DETS-1:0][dchc_pkg::SEC_N-1:0] win_vld_q;

	logic                                    vld_s1;
	dchc_pkg::in_item_t                      item_s1;
	logic [1:0]                              cmd_s1;
	logic [dchc_pkg::SEC_N-1:0][63:0]        win_rd_s1;
	logic [dchc_pkg::SEC_N-1:0]              win_v_s1;

	logic [dchc_pkg::PAIR_N-1:0][dchc_pkg::TIME_W-1:0] lt, rt;
	logic [dchc_pkg::SEC_N-1:0][dchc_pkg::TIME_W-1:0]  dr;
	logic [dchc_pkg::SEC_N-1:0][dchc_pkg::CTL_W-1:0]   csum;
	logic [dchc_pkg::PAIR_N-1:0][dchc_pkg::CTL_W-1:0]  diff;
	logic [dchc_pkg::SEC_N-1:0][31:0]                  cx, lo, hi;
	logic [dchc_pkg::SEC_N-1:0]                        ok;
	logic                                              det_ok_s1;
	logic                                              need;

	assign in_item = dchc_pkg::in_item_t'(s_tdata);
	assign s_tready = !vld_s1 || !q_full;
	assign accept = s_tvalid && s_tready;
	assign det_a = DET_W'(in_item.detector);
	assign in_det_ok = int'(in_item.detector) < NUM_DETS;
	assign win_we = accept && (s_tuser == dchc_pkg::CMD_WIN_WR) && in_det_ok &&
		!in_item.entry_index[2];

	always_ff @(posedge clk) begin
		if (win_we) begin
			win_mem_q[in_item.entry_index[1:0]][det_a] <= in_item.table_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_vld_q <= '0;
		end else if (win_we) begin
			win_vld_q[det_a][in_item.entry_index[1:0]] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
			cmd_s1 <= s_tuser;
			win_v_s1 <= win_vld_q[det_a];
			for (int s = 0; s < dchc_pkg::SEC_N; s++) begin
				win_rd_s1[s] <= win_mem_q[s][det_a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (accept) begin
			vld_s1 <= 1'b1;
		end else if (!q_full) begin
			vld_s1 <= 1'b0;
		end
	end

	always_comb begin
		lt[0] = item_s1.left_0 & TMASK;
		lt[1] = item_s1.left_1 & TMASK;
		rt[0] = item_s1.right_0 & TMASK;
		rt[1] = item_s1.right_1 & TMASK;
		dr[0] = item_s1.drift_0 & TMASK;
		dr[1] = item_s1.drift_1 & TMASK;
		dr[2] = item_s1.drift_2 & TMASK;
		dr[3] = item_s1.drift_3 & TMASK;
		for (int p = 0; p < dchc_pkg::PAIR_N; p++) begin
			diff[p] = {2'b00, lt[p]} - {2'b00, rt[p]};
		end
		for (int j = 0; j < dchc_pkg::SEC_N; j++) begin
			csum[j] = {2'b00, lt[j >> 1]} + {2'b00, rt[j >> 1]} - {1'b0, dr[j], 1'b0};
			cx[j] = {{(32 - dchc_pkg::CTL_W){csum[j][dchc_pkg::CTL_W-1]}}, csum[j]};
			lo[j] = win_v_s1[j] ? win_rd_s1[j][31:0] : 32'd0;
			hi[j] = win_v_s1[j] ? win_rd_s1[j][63:32] : 32'd0;
			ok[j] = ($signed(cx[j]) > $signed(lo[j])) && ($signed(cx[j]) < $signed(hi[j])) &&
				((lt[j >> 1] | rt[j >> 1]) != '0);
		end
	end

	assign det_ok_s1 = int'(item_s1.detector) < NUM_DETS;
	assign need = det_ok_s1 &&
		(((cmd_s1 == dchc_pkg::CMD_HIT) && (ok != '0)) ||
		 ((cmd_s1 == dchc_pkg::CMD_CAL_WR) && (item_s1.entry_index < 3'(dchc_pkg::CAL_N))));
	assign q_push = vld_s1 && !q_full && need;

	always_comb begin
		q_entry.is_cal = (cmd_s1 == dchc_pkg::CMD_CAL_WR);
		q_entry.det = item_s1.detector;
		q_entry.idx = item_s1.entry_index;
		q_entry.word = item_s1.table_word;
		q_entry.sec_ok = ok;
		q_entry.drift = dr;
		q_entry.csum = csum;
		q_entry.diff = diff;
	end

endmodule

@@ design/dchc_queue.sv @@
// Short queue of classified items between the front and back parts.
module dchc_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  dchc_pkg::q_entry_t  push_entry,
	output logic                full,
	input  logic                pop,
	output logic                head_vld,
	output dchc_pkg::q_entry_t  head
);

	dchc_pkg::q_entry_t              mem_q [dchc_pkg::QDEPTH];
	logic [dchc_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [dchc_pkg::QCNT_W-1:0]     cnt_q;

	assign full = (cnt_q == dchc_pkg::QCNT_W'(dchc_pkg::QDEPTH));
	assign head_vld = (cnt_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

@@ design/dchc_back.sv @@
// Back part: calibration table, result sequencer, multiply-add pipeline and output register.
module dchc_back #(
	parameter int NUM_DETS = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                head_vld,
	input  dchc_pkg::q_entry_t  head,
	output logic                pop,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [71:0]         m_tdata,
	output logic [0:0]          m_tuser,
	output logic                m_tlast
);

	localparam int DET_W = (NUM_DETS > 1) ? $clog2(NUM_DETS) : 1;

	logic [63:0]                               cal_mem_q [dchc_pkg::CAL_N][NUM_DETS];
	logic [NUM_DETS-1:0][dchc_pkg::CAL_N-1:0]  cal_vld_q;

	logic                          busy_q;
	dchc_pkg::q_entry_t            cur_q;
	logic [dchc_pkg::CAL_N-1:0]    rem_q;

	logic                          adv;
	dchc_pkg::q_entry_t            sel;
	logic [dchc_pkg::CAL_N-1:0]    mask, rem_next;
	logic [2:0]                    e;
	logic                          go, issue, cal_we;
	logic [DET_W-1:0]              sel_det_a, head_det_a;
	logic [dchc_pkg::CTL_W-1:0]    t_w, ctl_w;

	logic                          vld_s1, vert_s1, last_s1;
	logic [1:0]                    det_s1, sec_s1;
	logic signed [dchc_pkg::CTL_W-1:0] t_s1;
	logic [dchc_pkg::CTL_W-1:0]    ctl_s1;
	logic [63:0]                   cal_rd_s1;
	logic                          cal_v_s1;

	logic signed [31:0]            gain_w, off_w;
	logic signed [49:0]            prod_w;

	logic                          vld_s2, vert_s2, last_s2;
	logic [1:0]                    det_s2, sec_s2;
	logic [dchc_pkg::CTL_W-1:0]    ctl_s2;
	logic signed [49:0]            prod_s2;
	logic signed [31:0]            off_s2;

	logic signed [50:0]            sum_w;
	logic signed [dchc_pkg::POS_W-1:0] pos_w;

	logic                          out_vld_q, out_vert_q, out_last_q;
	dchc_pkg::res_t                out_q;

	assign adv = !out_vld_q || m_tready;
	assign sel = busy_q ? cur_q : head;
	assign mask = busy_q ? rem_q :
		(head.is_cal ? '0 : {|head.sec_ok[3:2], |head.sec_ok[1:0], head.sec_ok});
	assign rem_next = mask & (mask - 1'b1);
	assign go = adv && (busy_q || head_vld);
	assign pop = adv && !busy_q && head_vld;
	assign issue = go && !sel.is_cal;
	assign cal_we = pop && head.is_cal;
	assign sel_det_a = DET_W'(sel.det);
	assign head_det_a = DET_W'(head.det);

	always_comb begin
		e = '0;
		for (int i = dchc_pkg::CAL_N - 1; i >= 0; i--) begin
			if (mask[i]) begin
				e = 3'(i);
			end
		end
	end

	always_comb begin
		if (!e[2]) begin
			t_w = {2'b00, sel.drift[e[1:0]]};
			ctl_w = sel.csum[e[1:0]];
		end else begin
			t_w = sel.diff[e[0]];
			ctl_w = sel.diff[e[0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (go) begin
			busy_q <= !sel.is_cal && (rem_next != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			cur_q <= sel;
			rem_q <= rem_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cal_we) begin
			cal_mem_q[head.idx][head_det_a] <= head.word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_vld_q <= '0;
		end else if (cal_we) begin
			cal_vld_q[head_det_a][head.idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			out_vld_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s1 <= sel.det;
			vert_s1 <= !e[2];
			sec_s1 <= e[1:0];
			t_s1 <= t_w;
			ctl_s1 <= ctl_w;
			last_s1 <= (rem_next == '0);
			cal_rd_s1 <= cal_mem_q[e][sel_det_a];
			cal_v_s1 <= cal_vld_q[sel_det_a][e];
		end
	end

	assign gain_w = cal_v_s1 ? cal_rd_s1[63:32] : 32'sd0;
	assign off_w = cal_v_s1 ? cal_rd_s1[31:0] : 32'sd0;
	assign prod_w = gain_w * t_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			det_s2 <= det_s1;
			vert_s2 <= vert_s1;
			sec_s2 <= sec_s1;
			ctl_s2 <= ctl_s1;
			last_s2 <= last_s1;
			prod_s2 <= prod_w;
			off_s2 <= off_w;
		end
	end

	assign sum_w = 51'(off_s2) + 51'(prod_s2);

	always_comb begin
		priority if (sum_w > 51'(dchc_pkg::POS_MAX)) begin
			pos_w = dchc_pkg::POS_MAX;
		end else if (sum_w < 51'(dchc_pkg::POS_MIN)) begin
			pos_w = dchc_pkg::POS_MIN;
		end else begin
			pos_w = sum_w[dchc_pkg::POS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.pad <= '0;
			out_q.det_number <= det_s2;
			out_q.section <= sec_s2;
			out_q.position <= pos_w;
			out_q.control_value <= ctl_s2;
			out_vert_q <= vert_s2;
			out_last_q <= last_s2;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata = out_q;
	assign m_tuser = out_vert_q;
	assign m_tlast = out_last_q;

endmodule

@@ design/drift_chamber_hit_calibrator.sv @@
// Top level of the drift chamber hit calibrator.
// A hit item yields up to six results in order (y for each valid section 0..3, then x for
// delay line 0 and delay line 1), the last one marked by tlast; table writes and hits with
// no valid section yield nothing. The input side takes one item per cycle while the
// four-entry queue has room. The back end sends one result per cycle unless m_tready holds
// its output, through its single calibration table read port and multiplier; each hit result
// and each calibration write takes a turn of it, a window write none. A result passes the
// front stage register, the queue, back stages s1 and s2 and the output register.
module drift_chamber_hit_calibrator #(
	parameter int NUM_DETS = 4,
	parameter int TIME_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// detector, entry_index, drift_0..3, left_0, left_1, right_0, right_1, table_word
	input  logic [199:0] s_tdata,
	// command
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// det_number, section, position, control_value
	output logic [71:0]  m_tdata,
	// is_vertical
	output logic [0:0]   m_tuser,
	output logic         m_tlast
);

	logic               q_push, q_full, q_pop, q_vld;
	dchc_pkg::q_entry_t q_in, q_head;

	dchc_front #(
		.NUM_DETS  (NUM_DETS),
		.TIME_BITS (TIME_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_entry  (q_in)
	);

	dchc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head_vld   (q_vld),
		.head       (q_head)
	);

	dchc_back #(
		.NUM_DETS (NUM_DETS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_vld (q_vld),
		.head     (q_head),
		.pop      (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue push while full");

	a_pop_data: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_vld)
		else $error("queue pop while empty");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> q_full)
		else $error("input stalled with queue room");

	a_x_line: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> !m_tdata[3])
		else $error("x result with delay line above one");

endmodule

@@ tb/dchc_checker.sv @@
// Result checker for the drift chamber hit calibrator: tracks tables, predicts and compares.
`timescale 1ns / 1ps
module dchc_checker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [199:0] s_tdata,
	input  logic [1:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [71:0]  m_tdata,
	input  logic [0:0]   m_tuser,
	input  logic         m_tlast,
	output int           fail_count,
	output int           pending
);

	localparam int DETS = 4;

	typedef struct packed {
		logic [1:0]                 det;
		logic                       vertical;
		logic [1:0]                 sec;
		logic [dchc_pkg::POS_W-1:0] pos;
		logic [dchc_pkg::CTL_W-1:0] ctl;
		logic                       last;
	} hit_result_t;

	logic signed [31:0] win_lo [DETS*dchc_pkg::SEC_N];
	logic signed [31:0] win_hi [DETS*dchc_pkg::SEC_N];
	logic signed [31:0] cal_off [DETS*dchc_pkg::CAL_N];
	logic signed [31:0] cal_gain [DETS*dchc_pkg::CAL_N];
	hit_result_t expected_results [$];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	task automatic note_mismatch(input string what);
		$display("%0t ns mismatch: %s", $time, what);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want) begin
			note_mismatch($sformatf("%s got %h want %h", name, got, want));
		end
	endtask

	function automatic logic [dchc_pkg::POS_W-1:0] scale_position(input int unsigned e,
			input longint t);
		longint p;
		p = longint'(cal_off[e]) + longint'(cal_gain[e]) * t;
		if (p > longint'(dchc_pkg::POS_MAX)) begin
			p = longint'(dchc_pkg::POS_MAX);
		end
		if (p < longint'(dchc_pkg::POS_MIN)) begin
			p = longint'(dchc_pkg::POS_MIN);
		end
		return p[dchc_pkg::POS_W-1:0];
	endfunction

	task automatic predict_item(input logic [1:0] cmd, input dchc_pkg::in_item_t it);
		longint drift [dchc_pkg::SEC_N];
		longint lt [dchc_pkg::PAIR_N];
		longint rt [dchc_pkg::PAIR_N];
		longint csum;
		longint diff;
		logic [dchc_pkg::SEC_N-1:0] ok;
		int unsigned d;
		int first;
		int p;
		hit_result_t r;
		d = 32'(it.detector);
		case (cmd)
		dchc_pkg::CMD_WIN_WR: begin
			if (it.entry_index < dchc_pkg::SEC_N) begin
				win_lo[d*dchc_pkg::SEC_N + it.entry_index] = it.table_word[31:0];
				win_hi[d*dchc_pkg::SEC_N + it.entry_index] = it.table_word[63:32];
			end
		end
		dchc_pkg::CMD_CAL_WR: begin
			if (it.entry_index < dchc_pkg::CAL_N) begin
				cal_off[d*dchc_pkg::CAL_N + it.entry_index] = it.table_word[31:0];
				cal_gain[d*dchc_pkg::CAL_N + it.entry_index] = it.table_word[63:32];
			end
		end
		dchc_pkg::CMD_HIT: begin
			first = expected_results.size();
			drift[0] = longint'(it.drift_0);
			drift[1] = longint'(it.drift_1);
			drift[2] = longint'(it.drift_2);
			drift[3] = longint'(it.drift_3);
			lt[0] = longint'(it.left_0);
			lt[1] = longint'(it.left_1);
			rt[0] = longint'(it.right_0);
			rt[1] = longint'(it.right_1);
			for (int j = 0; j < dchc_pkg::SEC_N; j++) begin
				p = j / 2;
				csum = lt[p] + rt[p] - 2 * drift[j];
				ok[j] = csum > longint'(win_lo[d*dchc_pkg::SEC_N + j]) &&
					csum < longint'(win_hi[d*dchc_pkg::SEC_N + j]) &&
					!(lt[p] == 0 && rt[p] == 0);
				if (ok[j]) begin
					r.det = 2'(d);
					r.vertical = 1'b1;
					r.sec = 2'(j);
					r.pos = scale_position(d*dchc_pkg::CAL_N + j, drift[j]);
					r.ctl = csum[dchc_pkg::CTL_W-1:0];
					r.last = 1'b0;
					expected_results.push_back(r);
				end
			end
			for (int j = 0; j < dchc_pkg::PAIR_N; j++) begin
				if (ok[2*j] || ok[2*j+1]) begin
					diff = lt[j] - rt[j];
					r.det = 2'(d);
					r.vertical = 1'b0;
					r.sec = 2'(j);
					r.pos = scale_position(d*dchc_pkg::CAL_N + dchc_pkg::SEC_N + j, diff);
					r.ctl = diff[dchc_pkg::CTL_W-1:0];
					r.last = 1'b0;
					expected_results.push_back(r);
				end
			end
			if (expected_results.size() > first) begin
				expected_results[expected_results.size()-1].last = 1'b1;
			end
		end
		default: ;
		endcase
	endtask

	task automatic check_result();
		dchc_pkg::res_t got;
		hit_result_t want;
		got = dchc_pkg::res_t'(m_tdata);
		if (expected_results.size() == 0) begin
			note_mismatch($sformatf("unexpected result det %0d sec %0d pos %h",
				got.det_number, got.section, got.position));
		end else begin
			want = expected_results.pop_front();
			check_field("det_number", 64'(got.det_number), 64'(want.det));
			check_field("is_vertical", 64'(m_tuser[0]), 64'(want.vertical));
			check_field("section", 64'(got.section), 64'(want.sec));
			check_field("position", 64'({got.position}), 64'(want.pos));
			check_field("control_value", 64'({got.control_value}), 64'(want.ctl));
			check_field("last", 64'(m_tlast), 64'(want.last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DETS*dchc_pkg::SEC_N; i++) begin
				win_lo[i] = '0;
				win_hi[i] = '0;
			end
			for (int i = 0; i < DETS*dchc_pkg::CAL_N; i++) begin
				cal_off[i] = '0;
				cal_gain[i] = '0;
			end
			expected_results.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				check_result();
			end
			if (s_tvalid && s_tready) begin
				predict_item(s_tuser, dchc_pkg::in_item_t'(s_tdata));
			end
		end
		pending = expected_results.size();
	end

endmodule

@@ tb/tb.sv @@
// Testbench top for the drift chamber hit calibrator: reset, stimulus, back pressure, verdict.
`timescale 1ns / 1ps
module tb;

	localparam logic [1:0] CMD_SPARE = 2'd3;
	localparam int LIMIT = 400000;
	localparam int RANDOM_ITEMS = 347;
	localparam int CALM_TAIL = 60;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [199:0] s_tdata = '0;
	logic [1:0]   s_tuser = dchc_pkg::CMD_HIT;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [71:0]  m_tdata;
	logic [0:0]   m_tuser;
	logic         m_tlast;
	int           fail_count;
	int           pending;
	int           cycles = 0;
	bit           idling = 1'b1;

	drift_chamber_hit_calibrator dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	dchc_checker calib_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.fail_count(fail_count),
		.pending(pending)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("drift_chamber_hit_calibrator verification failed");
			$finish;
		end
	end

	always begin
		@(negedge clk);
		if (idling && $urandom_range(0, 7) == 0) begin
			m_tready <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		m_tready <= 1'b1;
	end

	function automatic dchc_pkg::in_item_t hit_item(input logic [1:0] det,
			input logic [15:0] d0, input logic [15:0] d1,
			input logic [15:0] d2, input logic [15:0] d3,
			input logic [15:0] l0, input logic [15:0] r0,
			input logic [15:0] l1, input logic [15:0] r1);
		dchc_pkg::in_item_t it;
		it = '0;
		it.detector = det;
		it.entry_index = 3'($urandom);
		it.drift_0 = d0;
		it.drift_1 = d1;
		it.drift_2 = d2;
		it.drift_3 = d3;
		it.left_0 = l0;
		it.right_0 = r0;
		it.left_1 = l1;
		it.right_1 = r1;
		it.table_word = {$urandom, $urandom};
		return it;
	endfunction

	function automatic dchc_pkg::in_item_t table_item(input logic [1:0] det,
			input logic [2:0] idx, input logic [31:0] lo, input logic [31:0] hi);
		dchc_pkg::in_item_t it;
		it = hit_item(det, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
			16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
		it.entry_index = idx;
		it.table_word = {hi, lo};
		return it;
	endfunction

	function automatic dchc_pkg::in_item_t random_hit();
		logic [15:0] lt [2];
		logic [15:0] rt [2];
		logic [15:0] dt [4];
		int shape;
		shape = $urandom_range(0, 7);
		for (int p = 0; p < 2; p++) begin
			lt[p] = (shape == 2) ? 16'($urandom_range(0, 40)) : 16'($urandom);
			rt[p] = (shape == 2) ? 16'($urandom_range(0, 40)) : 16'($urandom);
		end
		if (shape == 0) begin
			lt[0] = '0;
			rt[0] = '0;
		end
		if (shape == 1) begin
			lt[1] = '0;
			rt[1] = '0;
		end
		for (int j = 0; j < 4; j++) begin
			if ($urandom_range(0, 1)) begin
				dt[j] = 16'($urandom);
			end else begin
				dt[j] = 16'((int'(lt[j/2]) + int'(rt[j/2])) / 2 +
					int'($urandom_range(0, 40)) - 20);
			end
		end
		return hit_item(2'($urandom_range(0, 3)), dt[0], dt[1], dt[2], dt[3],
			lt[0], rt[0], lt[1], rt[1]);
	endfunction

	function automatic logic [63:0] window_word();
		int lo;
		int hi;
		int c;
		case ($urandom_range(0, 2))
		0: begin
			lo = $urandom;
			hi = $urandom;
		end
		1: begin
			lo = -int'($urandom_range(0, 140000));
			hi = $urandom_range(0, 140000);
		end
		default: begin
			c = int'($urandom_range(0, 131070)) - 65535;
			lo = c - int'($urandom_range(0, 3000));
			hi = c + int'($urandom_range(0, 3000));
		end
		endcase
		return {hi, lo};
	endfunction

	function automatic logic [31:0] edge_value();
		case ($urandom_range(0, 4))
		0: return 32'h7FFF_FFFF;
		1: return 32'h8000_0000;
		2: return 32'h0000_0000;
		3: return 32'hFFFF_FFFF;
		default: return 32'h0001_0000;
		endcase
	endfunction

	function automatic logic [63:0] cal_word();
		case ($urandom_range(0, 2))
		0: return {$urandom, $urandom};
		1: return {32'(int'($urandom_range(0, 262144)) - 131072), 32'($urandom)};
		default: return {edge_value(), edge_value()};
		endcase
	endfunction

	task automatic send_item(input logic [1:0] cmd, input dchc_pkg::in_item_t it);
		if (idling && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		s_tuser <= cmd;
		s_tdata <= it;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	initial begin
		int accepted;
		int sel;
		dchc_pkg::in_item_t it;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_item(dchc_pkg::CMD_HIT, hit_item(0, 100, 200, 300, 400, 1000, 500, 1000, 500));
		for (int j = 0; j < dchc_pkg::SEC_N; j++) begin
			send_item(dchc_pkg::CMD_WIN_WR,
				table_item(0, 3'(j), 32'h8000_0000, 32'h7FFF_FFFF));
		end
		send_item(dchc_pkg::CMD_CAL_WR, table_item(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_item(dchc_pkg::CMD_CAL_WR, table_item(0, 1, 32'h8000_0000, 32'h8000_0000));
		send_item(dchc_pkg::CMD_CAL_WR, table_item(0, 2, 32'h0000_0000, 32'h0001_0000));
		send_item(dchc_pkg::CMD_CAL_WR, table_item(0, 3, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		send_item(dchc_pkg::CMD_CAL_WR, table_item(0, 4, 32'h7FFF_FFFF, 32'h8000_0000));
		send_item(dchc_pkg::CMD_CAL_WR, table_item(0, 5, 32'h8000_0000, 32'h7FFF_FFFF));
		send_item(dchc_pkg::CMD_HIT, hit_item(0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF));
		send_item(dchc_pkg::CMD_HIT, hit_item(0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(dchc_pkg::CMD_HIT, hit_item(0, 0, 0, 0, 1, 0, 0, 16'hFFFF, 16'hFFFF));
		send_item(dchc_pkg::CMD_WIN_WR, table_item(0, 7, 32'h0000_0005, 32'h0000_0006));
		send_item(dchc_pkg::CMD_CAL_WR, table_item(0, 6, $urandom, $urandom));
		send_item(dchc_pkg::CMD_CAL_WR, table_item(0, 7, $urandom, $urandom));
		send_item(CMD_SPARE, hit_item(0, 0, 0, 0, 0, 16'hFFFF, 0, 16'hFFFF, 0));
		send_item(dchc_pkg::CMD_WIN_WR, table_item(1, 2, 32'd10, 32'd12));
		send_item(dchc_pkg::CMD_HIT, hit_item(1, 0, 0, 5, 0, 0, 0, 21, 0));
		send_item(dchc_pkg::CMD_HIT, hit_item(1, 0, 0, 5, 0, 0, 0, 22, 0));
		send_item(dchc_pkg::CMD_HIT, hit_item(1, 0, 0, 5, 0, 0, 0, 20, 0));
		send_item(dchc_pkg::CMD_HIT, hit_item(0, 0, 0, 0, 0, 1, 0, 0, 0));

		accepted = 0;
		while (accepted < RANDOM_ITEMS) begin
			if (accepted >= RANDOM_ITEMS - CALM_TAIL) begin
				idling = 1'b0;
			end else if (accepted % 50 == 0) begin
				idling = $urandom_range(0, 3) != 0;
			end
			sel = $urandom_range(0, 19);
			if (sel < 11) begin
				send_item(dchc_pkg::CMD_HIT, random_hit());
			end else if (sel < 14) begin
				it = table_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 3)), '0, '0);
				it.table_word = window_word();
				send_item(dchc_pkg::CMD_WIN_WR, it);
			end else if (sel < 17) begin
				it = table_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 5)), '0, '0);
				it.table_word = cal_word();
				send_item(dchc_pkg::CMD_CAL_WR, it);
			end else if (sel == 17) begin
				send_item(dchc_pkg::CMD_WIN_WR, table_item(2'($urandom_range(0, 3)),
					3'($urandom_range(4, 7)), $urandom, $urandom));
			end else if (sel == 18) begin
				send_item(dchc_pkg::CMD_CAL_WR, table_item(2'($urandom_range(0, 3)),
					3'($urandom_range(6, 7)), $urandom, $urandom));
			end else begin
				send_item(CMD_SPARE, random_hit());
			end
			accepted++;
		end

		idling = 1'b0;
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (fail_count == 0) begin
			$display("drift_chamber_hit_calibrator verification clean");
		end else begin
			$display("drift_chamber_hit_calibrator verification failed");
		end
		$finish;
	end

endmodule
